[design/v3a_pkg.sv]
// ----------------------------------------------------------------------------
// v3a_pkg
// shared widths, command and fault codes, and request/response types
// for the three-component vector alu
// ----------------------------------------------------------------------------
package v3a_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int DIV_W     = DATA_W + FRAC_BITS;
   localparam int DEN_W     = DATA_W;
   localparam int ROOT_W    = DATA_W;
   localparam int RAD_W     = 2 * DATA_W;
   localparam int REM_W     = ROOT_W + 3;
   localparam int PROD_W    = 2 * DATA_W + 2;
   localparam int WIDE_W    = PROD_W + 2;

   localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [3:0] CMD_ADD       = 4'd0;
   localparam logic [3:0] CMD_SUB       = 4'd1;
   localparam logic [3:0] CMD_SCALE     = 4'd2;
   localparam logic [3:0] CMD_DIV       = 4'd3;
   localparam logic [3:0] CMD_DOT       = 4'd4;
   localparam logic [3:0] CMD_CROSS     = 4'd5;
   localparam logic [3:0] CMD_NORM      = 4'd6;
   localparam logic [3:0] CMD_NORMALIZE = 4'd7;
   localparam logic [3:0] CMD_DIST      = 4'd8;

   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_DIV0 = 2'd1;
   localparam logic [1:0] FAULT_OVF  = 2'd2;

   typedef struct packed {
      logic [3:0]               command;
      logic signed [DATA_W-1:0] a_x;
      logic signed [DATA_W-1:0] a_y;
      logic signed [DATA_W-1:0] a_z;
      logic signed [DATA_W-1:0] b_x;
      logic signed [DATA_W-1:0] b_y;
      logic signed [DATA_W-1:0] b_z;
      logic signed [DATA_W-1:0] scalar_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_x;
      logic signed [DATA_W-1:0] result_y;
      logic signed [DATA_W-1:0] result_z;
      logic signed [DATA_W-1:0] result_scalar;
      logic                     is_equal;
      logic [1:0]               fault;
   } rsp_type;

endpackage

[design/v3a_sqrt.sv]
// ----------------------------------------------------------------------------
// v3a_sqrt
// pipelined integer square root, one root bit per stage, floored result
// ----------------------------------------------------------------------------
module v3a_sqrt import v3a_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  rad_data,
   output logic [ROOT_W-1:0] root_data
);

   logic [RAD_W-1:0]  val_ff    [ROOT_W];
   logic [REM_W-1:0]  rem_ff    [ROOT_W];
   logic [ROOT_W-1:0] root_ff   [ROOT_W];
   logic [RAD_W-1:0]  val_in    [ROOT_W];
   logic [REM_W-1:0]  rem_in    [ROOT_W];
   logic [ROOT_W-1:0] root_in   [ROOT_W];
   logic [RAD_W-1:0]  val_prev  [ROOT_W];
   logic [REM_W-1:0]  rem_prev  [ROOT_W];
   logic [ROOT_W-1:0] root_prev [ROOT_W];
   logic [REM_W-1:0]  part      [ROOT_W];
   logic [REM_W-1:0]  trial     [ROOT_W];
   logic              take      [ROOT_W];

   always_comb begin
      val_prev[0]  = rad_data;
      rem_prev[0]  = '0;
      root_prev[0] = '0;
      for (int i = 1; i < ROOT_W; i++) begin
         val_prev[i]  = val_ff[i-1];
         rem_prev[i]  = rem_ff[i-1];
         root_prev[i] = root_ff[i-1];
      end
      // bring down two radicand bits, try (root << 2) | 1
      for (int i = 0; i < ROOT_W; i++) begin
         part[i]    = {rem_prev[i][REM_W-3:0], val_prev[i][RAD_W-1 -: 2]};
         trial[i]   = {1'b0, root_prev[i], 2'b01};
         take[i]    = (part[i] >= trial[i]);
         rem_in[i]  = take[i] ? (part[i] - trial[i]) : part[i];
         root_in[i] = {root_prev[i][ROOT_W-2:0], take[i]};
         val_in[i]  = {val_prev[i][RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < ROOT_W; i++) begin
            val_ff[i]  <= val_in[i];
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
         end
      end
   end

   assign root_data = root_ff[ROOT_W-1];

endmodule

[design/v3a_div.sv]
// ----------------------------------------------------------------------------
// v3a_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module v3a_div import v3a_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [DIV_W-1:0] num_data,
   input  logic [DEN_W-1:0] den_data,
   output logic [DIV_W-1:0] quo_data
);

   // nq holds the unused dividend bits on top and the quotient bits below
   logic [DIV_W-1:0] nq_ff    [DIV_W];
   logic [DEN_W-1:0] rem_ff   [DIV_W];
   logic [DEN_W-1:0] dn_ff    [DIV_W];
   logic [DIV_W-1:0] nq_in    [DIV_W];
   logic [DEN_W-1:0] rem_in   [DIV_W];
   logic [DIV_W-1:0] nq_prev  [DIV_W];
   logic [DEN_W-1:0] rem_prev [DIV_W];
   logic [DEN_W-1:0] dn_prev  [DIV_W];
   logic [DEN_W:0]   part     [DIV_W];
   logic [DEN_W:0]   diff     [DIV_W];
   logic             take     [DIV_W];

   always_comb begin
      nq_prev[0]  = num_data;
      rem_prev[0] = '0;
      dn_prev[0]  = den_data;
      for (int i = 1; i < DIV_W; i++) begin
         nq_prev[i]  = nq_ff[i-1];
         rem_prev[i] = rem_ff[i-1];
         dn_prev[i]  = dn_ff[i-1];
      end
      for (int i = 0; i < DIV_W; i++) begin
         part[i]   = {rem_prev[i], nq_prev[i][DIV_W-1]};
         diff[i]   = part[i] - {1'b0, dn_prev[i]};
         take[i]   = (part[i] >= {1'b0, dn_prev[i]});
         rem_in[i] = take[i] ? diff[i][DEN_W-1:0] : part[i][DEN_W-1:0];
         nq_in[i]  = {nq_prev[i][DIV_W-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIV_W; i++) begin
            nq_ff[i]  <= nq_in[i];
            rem_ff[i] <= rem_in[i];
            dn_ff[i]  <= dn_prev[i];
         end
      end
   end

   assign quo_data = nq_ff[DIV_W-1];

endmodule

[design/vector3_alu.sv]
// ----------------------------------------------------------------------------
// vector3_alu
// three-component vector alu in signed fixed point: add, sub, scale, divide,
// dot, cross, norm, normalize and distance, with saturation and fault codes
// ----------------------------------------------------------------------------
// the alu takes one request per clock and returns one response per request,
// in order; every request, whatever its command, takes the same path: the
// front stages, the square root pipe (one root bit per stage) and then the
// divider pipe (one quotient bit per stage), with Q16.16 data; responses
// wait in a two-entry output queue, and req_ready drops only while both
// entries are full, so a slow consumer holds the pipe without losing or
// repeating a request
module vector3_alu import v3a_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // side data that travels with each request down the pipe
   typedef struct packed {
      logic [3:0]              cmd;
      logic                    eq;
      logic                    big;
      logic                    den_zero;
      logic [2:0][DATA_W-1:0]  a;
      logic [DATA_W-1:0]       s;
      logic [2:0][DATA_W-1:0]  res;
      logic [DATA_W-1:0]       sc;
      logic [1:0]              fault;
   } side_type;

   localparam logic signed [DATA_W:0] MAX33  = {2'b00, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W:0] NMAX33 = {2'b11, {(DATA_W-2){1'b0}}, 1'b1};
   localparam logic signed [WIDE_W-1:0] WMAX = {{(WIDE_W-DATA_W){1'b0}}, MAX_VAL};
   localparam logic signed [WIDE_W-1:0] WMIN = {{(WIDE_W-DATA_W){1'b1}}, MIN_VAL};
   localparam logic [DIV_W-1:0] Q_POS_LIM = {{(DIV_W-DATA_W){1'b0}}, MAX_VAL};
   localparam logic [DIV_W-1:0] Q_NEG_LIM = {{(DIV_W-DATA_W){1'b0}}, MIN_VAL};

   // saturate to the data range, top bit flags overflow
   function automatic logic [DATA_W:0] sat_fn(input logic signed [WIDE_W-1:0] v);
      logic [DATA_W:0] r;
      if (v > WMAX) begin
         r = {1'b1, MAX_VAL};
      end else if (v < WMIN) begin
         r = {1'b1, MIN_VAL};
      end else begin
         r = {1'b0, v[DATA_W-1:0]};
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W:0] ext_fn(input logic [DATA_W-1:0] v);
      return {v[DATA_W-1], v};
   endfunction

   function automatic logic [DATA_W-1:0] mag_fn(input logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? (~v + 1'b1) : v;
   endfunction

   // pipe control and output queue
   logic       pipe_en;
   logic       push;
   logic       pop;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   rsp_type    head_ff;
   rsp_type    skid_ff;
   rsp_type    fin;

   // front stages
   logic                     v1_ff, v2_ff, v3_ff;
   side_type                 side0, side1_ff, side2_in, side2_ff, side3_ff, side4_in;
   logic signed [DATA_W:0]   as_in  [3];
   logic signed [DATA_W:0]   as1_ff [3];
   logic signed [DATA_W:0]   opx    [6];
   logic signed [DATA_W:0]   opy    [6];
   logic signed [PROD_W-1:0] prod2_ff [6];
   logic signed [WIDE_W-1:0] sum3;
   logic signed [WIDE_W-1:0] w_in   [3];
   logic signed [WIDE_W-1:0] w3_ff  [3];
   logic signed [WIDE_W-1:0] fl     [3];
   logic [DATA_W:0]          sat_as [3];
   logic [DATA_W:0]          sat_w  [3];
   logic [RAD_W-1:0]         rad3_ff;
   logic [DATA_W-1:0]        ra     [3];
   logic [DATA_W-1:0]        rb     [3];

   // square root and divider sections
   logic                     vq_ff      [ROOT_W];
   side_type                 sq_side_ff [ROOT_W];
   logic [ROOT_W-1:0]        sqrt_root;
   side_type                 side5_in;
   logic [DEN_W-1:0]         den;
   logic [DIV_W-1:0]         num    [3];
   logic [DIV_W-1:0]         quo    [3];
   logic                     vd_ff      [DIV_W];
   side_type                 dv_side_ff [DIV_W];
   side_type                 sf;
   logic [DATA_W-1:0]        qr     [3];
   logic                     qo     [3];
   logic [2:0][DATA_W-1:0]   res_f;
   logic [1:0]               fault_f;
   logic                     neg;

   // stall only when the output queue is full, ready has no path from rsp_ready
   assign pipe_en   = (count_ff != 2'd2);
   assign req_ready = pipe_en;
   assign push      = pipe_en && vd_ff[DIV_W-1];
   assign pop       = rsp_valid && rsp_ready;

   // stage 0: sums and differences, equality, distance range check
   assign ra[0] = req_data.a_x;
   assign ra[1] = req_data.a_y;
   assign ra[2] = req_data.a_z;
   assign rb[0] = req_data.b_x;
   assign rb[1] = req_data.b_y;
   assign rb[2] = req_data.b_z;

   always_comb begin
      side0          = '0;
      side0.cmd      = req_data.command;
      side0.s        = req_data.scalar_in;
      side0.fault    = FAULT_NONE;
      side0.eq       = (ra[0] == rb[0]) && (ra[1] == rb[1]) && (ra[2] == rb[2]);
      for (int i = 0; i < 3; i++) begin
         side0.a[i] = ra[i];
         if (req_data.command == CMD_SUB || req_data.command == CMD_DIST) begin
            as_in[i] = ext_fn(ra[i]) - ext_fn(rb[i]);
         end else begin
            as_in[i] = ext_fn(ra[i]) + ext_fn(rb[i]);
         end
         // a difference of exactly the most negative value also counts as too big
         if (as_in[i] > MAX33 || as_in[i] < NMAX33) begin
            side0.big = 1'b1;
         end
      end
   end

   // stage 1: operand select for six multipliers, add/sub saturation
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         opx[k] = '0;
         opy[k] = '0;
      end
      case (side1_ff.cmd)
         CMD_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               opx[i] = ext_fn(side1_ff.a[i]);
               opy[i] = ext_fn(side1_ff.s);
            end
         end
         CMD_DOT: begin
            // b recovered from a + b
            for (int i = 0; i < 3; i++) begin
               opx[i] = ext_fn(side1_ff.a[i]);
               opy[i] = as1_ff[i] - ext_fn(side1_ff.a[i]);
            end
         end
         CMD_CROSS: begin
            // b recovered from a + b
            opx[0] = ext_fn(side1_ff.a[1]);  opy[0] = as1_ff[2] - ext_fn(side1_ff.a[2]);
            opx[1] = ext_fn(side1_ff.a[2]);  opy[1] = as1_ff[0] - ext_fn(side1_ff.a[0]);
            opx[2] = ext_fn(side1_ff.a[0]);  opy[2] = as1_ff[1] - ext_fn(side1_ff.a[1]);
            opx[3] = ext_fn(side1_ff.a[2]);  opy[3] = as1_ff[1] - ext_fn(side1_ff.a[1]);
            opx[4] = ext_fn(side1_ff.a[0]);  opy[4] = as1_ff[2] - ext_fn(side1_ff.a[2]);
            opx[5] = ext_fn(side1_ff.a[1]);  opy[5] = as1_ff[0] - ext_fn(side1_ff.a[0]);
         end
         CMD_NORM, CMD_NORMALIZE: begin
            for (int i = 0; i < 3; i++) begin
               opx[i] = ext_fn(side1_ff.a[i]);
               opy[i] = ext_fn(side1_ff.a[i]);
            end
         end
         CMD_DIST: begin
            for (int i = 0; i < 3; i++) begin
               opx[i] = as1_ff[i];
               opy[i] = as1_ff[i];
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      side2_in = side1_ff;
      for (int i = 0; i < 3; i++) begin
         sat_as[i] = sat_fn(WIDE_W'(as1_ff[i]));
      end
      if (side1_ff.cmd == CMD_ADD || side1_ff.cmd == CMD_SUB) begin
         for (int i = 0; i < 3; i++) begin
            side2_in.res[i] = sat_as[i][DATA_W-1:0];
         end
         if (sat_as[0][DATA_W] || sat_as[1][DATA_W] || sat_as[2][DATA_W]) begin
            side2_in.fault = FAULT_OVF;
         end
      end
   end

   // stage 2: combine products, exact before scaling
   always_comb begin
      sum3 = WIDE_W'(prod2_ff[0]) + WIDE_W'(prod2_ff[1]) + WIDE_W'(prod2_ff[2]);
      for (int i = 0; i < 3; i++) begin
         if (side2_ff.cmd == CMD_CROSS) begin
            w_in[i] = WIDE_W'(prod2_ff[i]) - WIDE_W'(prod2_ff[i+3]);
         end else begin
            w_in[i] = WIDE_W'(prod2_ff[i]);
         end
      end
      if (side2_ff.cmd == CMD_DOT) begin
         w_in[0] = sum3;
      end
   end

   // stage 3: floor scaling and saturation of scale, dot and cross
   always_comb begin
      side4_in = side3_ff;
      for (int i = 0; i < 3; i++) begin
         fl[i]    = w3_ff[i] >>> FRAC_BITS;
         sat_w[i] = sat_fn(fl[i]);
      end
      case (side3_ff.cmd)
         CMD_SCALE, CMD_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               side4_in.res[i] = sat_w[i][DATA_W-1:0];
            end
            if (sat_w[0][DATA_W] || sat_w[1][DATA_W] || sat_w[2][DATA_W]) begin
               side4_in.fault = FAULT_OVF;
            end
         end
         CMD_DOT: begin
            side4_in.sc = sat_w[0][DATA_W-1:0];
            if (sat_w[0][DATA_W]) begin
               side4_in.fault = FAULT_OVF;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         side1_ff <= side0;
         side2_ff <= side2_in;
         side3_ff <= side2_ff;
         rad3_ff  <= sum3[RAD_W-1:0];
         for (int i = 0; i < 3; i++) begin
            as1_ff[i] <= as_in[i];
            w3_ff[i]  <= w_in[i];
         end
         for (int k = 0; k < 6; k++) begin
            prod2_ff[k] <= opx[k] * opy[k];
         end
      end
   end

   // square root of the sum of squares
   v3a_sqrt u_sqrt (
      .clock     (clock),
      .en        (pipe_en),
      .rad_data  (rad3_ff),
      .root_data (sqrt_root)
   );

   // norm and distance results, divider operands
   always_comb begin
      side5_in = sq_side_ff[ROOT_W-1];
      case (side5_in.cmd)
         CMD_NORM: begin
            if (sqrt_root[ROOT_W-1]) begin
               side5_in.sc    = MAX_VAL;
               side5_in.fault = FAULT_OVF;
            end else begin
               side5_in.sc = sqrt_root;
            end
         end
         CMD_DIST: begin
            if (side5_in.big || sqrt_root[ROOT_W-1]) begin
               side5_in.sc    = MAX_VAL;
               side5_in.fault = FAULT_OVF;
            end else begin
               side5_in.sc = sqrt_root;
            end
         end
         default: begin
         end
      endcase
      den = (side5_in.cmd == CMD_DIV) ? mag_fn(side5_in.s) : sqrt_root;
      side5_in.den_zero = (den == '0);
      for (int i = 0; i < 3; i++) begin
         num[i] = {mag_fn(side5_in.a[i]), {FRAC_BITS{1'b0}}};
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_div
      v3a_div u_div (
         .clock    (clock),
         .en       (pipe_en),
         .num_data (num[g]),
         .den_data (den),
         .quo_data (quo[g])
      );
   end

   // side lines alongside the square root and divider pipes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROOT_W; i++) begin
            vq_ff[i] <= 1'b0;
         end
         for (int i = 0; i < DIV_W; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else if (pipe_en) begin
         vq_ff[0] <= v3_ff;
         for (int i = 1; i < ROOT_W; i++) begin
            vq_ff[i] <= vq_ff[i-1];
         end
         vd_ff[0] <= vq_ff[ROOT_W-1];
         for (int i = 1; i < DIV_W; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sq_side_ff[0] <= side4_in;
         for (int i = 1; i < ROOT_W; i++) begin
            sq_side_ff[i] <= sq_side_ff[i-1];
         end
         dv_side_ff[0] <= side5_in;
         for (int i = 1; i < DIV_W; i++) begin
            dv_side_ff[i] <= dv_side_ff[i-1];
         end
      end
   end

   // final stage: sign and saturate the quotients, divide-by-zero handling
   always_comb begin
      sf      = dv_side_ff[DIV_W-1];
      res_f   = sf.res;
      fault_f = sf.fault;
      neg     = 1'b0;
      for (int i = 0; i < 3; i++) begin
         neg   = sf.a[i][DATA_W-1] ^ ((sf.cmd == CMD_DIV) && sf.s[DATA_W-1]);
         qo[i] = 1'b0;
         if (neg) begin
            if (quo[i] > Q_NEG_LIM) begin
               qr[i] = MIN_VAL;
               qo[i] = 1'b1;
            end else begin
               qr[i] = ~quo[i][DATA_W-1:0] + 1'b1;
            end
         end else begin
            if (quo[i] > Q_POS_LIM) begin
               qr[i] = MAX_VAL;
               qo[i] = 1'b1;
            end else begin
               qr[i] = quo[i][DATA_W-1:0];
            end
         end
      end
      case (sf.cmd)
         CMD_DIV: begin
            if (sf.den_zero) begin
               // zero divisor: each nonzero component goes to the end of its sign, zero stays zero
               fault_f = FAULT_DIV0;
               for (int i = 0; i < 3; i++) begin
                  if (sf.a[i][DATA_W-1]) begin
                     res_f[i] = MIN_VAL;
                  end else if (sf.a[i] == '0) begin
                     res_f[i] = '0;
                  end else begin
                     res_f[i] = MAX_VAL;
                  end
               end
            end else begin
               for (int i = 0; i < 3; i++) begin
                  res_f[i] = qr[i];
               end
               if (qo[0] || qo[1] || qo[2]) begin
                  fault_f = FAULT_OVF;
               end
            end
         end
         CMD_NORMALIZE: begin
            // zero vector stays zero
            if (!sf.den_zero) begin
               for (int i = 0; i < 3; i++) begin
                  res_f[i] = qr[i];
               end
               if (qo[0] || qo[1] || qo[2]) begin
                  fault_f = FAULT_OVF;
               end
            end
         end
         default: begin
         end
      endcase
      fin.result_x      = res_f[0];
      fin.result_y      = res_f[1];
      fin.result_z      = res_f[2];
      fin.result_scalar = sf.sc;
      fin.is_equal      = sf.eq;
      fin.fault         = fault_f;
   end

   // two-entry output queue: head is shown, skid catches one more
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_ff <= fin;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_ff <= fin;
            end else if (push) begin
               skid_ff <= fin;
            end
         end
         2'd2: begin
            if (pop) begin
               head_ff <= skid_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = head_ff;

   // queued response moves up to the head when the head is taken
   a_skid_handoff: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && rsp_ready) |=> (count_ff == 2'd1 && rsp_data == $past(skid_ff)))
      else $error("skid entry lost on handoff");

   // divide-by-zero fault only comes from a divide request
   a_div0_cmd: assert property (@(posedge clock) disable iff (reset)
      (vd_ff[DIV_W-1] && fin.fault == FAULT_DIV0) |-> (sf.cmd == CMD_DIV))
      else $error("divide-by-zero fault on another command");

   // equal vectors are at distance zero
   a_dist_equal: assert property (@(posedge clock) disable iff (reset)
      (vd_ff[DIV_W-1] && sf.cmd == CMD_DIST && sf.eq)
         |-> (fin.result_scalar == '0 && fin.fault == FAULT_NONE))
      else $error("nonzero distance between equal vectors");

   // scalar commands leave the vector result at zero
   a_scalar_zero_vec: assert property (@(posedge clock) disable iff (reset)
      (vd_ff[DIV_W-1] && (sf.cmd == CMD_DOT || sf.cmd == CMD_NORM || sf.cmd == CMD_DIST))
         |-> (fin.result_x == '0 && fin.result_y == '0 && fin.result_z == '0))
      else $error("vector result on a scalar command");

endmodule
